// ===== design/psc_pkg.sv =====
// Shared types and constants for the palindromic substring counter.
package psc_pkg;

    localparam int DEF_MAX_LEN = 64;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    // Which rule decides a cell: single char, adjacent pair, or longer span.
    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_PAIR,
        KIND_SPAN
    } cell_kind_t;

    typedef struct packed {
        logic       clear;
        logic       step;
        cell_kind_t kind;
    } psc_op_t;

endpackage

// ===== design/psc_in_if.sv =====
// Character channel: one string byte per word, with an end-of-string mark.
interface psc_in_if;
    import psc_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/psc_out_if.sv =====
// Result channel: palindrome count and truncation flag.
interface psc_out_if;
    import psc_pkg::*;

    logic   valid;
    logic   ready;
    count_t palindrome_count;
    logic   overflow;

    modport source (output valid, output palindrome_count, output overflow, input ready);
    modport sink   (input valid, input palindrome_count, input overflow, output ready);
endinterface

// ===== design/psc_unit.sv =====
// Shared compare unit and saturating palindrome tally.
module psc_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  psc_pkg::psc_op_t op,
    input  psc_pkg::char_t   char_a,
    input  psc_pkg::char_t   char_b,
    input  logic             inner,
    output logic             hit,
    output psc_pkg::count_t  total
);
    import psc_pkg::*;

    count_t total_reg;
    count_t total_next;
    logic   ends_eq;

    assign ends_eq = (char_a == char_b);

    always_comb
    begin
        unique case (op.kind)
            KIND_SINGLE: hit = 1'b1;
            KIND_PAIR:   hit = ends_eq;
            KIND_SPAN:   hit = ends_eq && inner;
            default:     hit = 1'b0;
        endcase
    end

    always_comb
    begin
        total_next = total_reg;
        if (op.clear)
        begin
            total_next = '0;
        end
        else if (op.step && hit && (total_reg != COUNT_MAX))
        begin
            total_next = total_reg + count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

// ===== design/palindromic_substring_counter_top.sv =====
// Palindromic substring counter: top level with char store and sequencer.
//
// Send one string as a run of character words, the final one marked with
// last. The block takes one word per cycle while loading. After the final
// word it stops taking words and counts every palindromic substring of the
// stored string, walking the table one diagonal (gap) at a time, left to
// right within a diagonal. One shared compare unit judges each cell: a read
// state fetches both end characters from the char store (a memory with two
// registered read ports), and the compare state after it compares them and
// folds in the flag of the inner span kept from two diagonals back. Once
// the count is done the result word is held until taken; loading of the
// next string starts the cycle after. Characters beyond MAX_LEN are dropped
// and the overflow bit is set in the result; the count then covers the
// first MAX_LEN characters. The count saturates at 4095, which can only be
// reached with MAX_LEN of 90 or more.
module palindromic_substring_counter_top #(
    parameter int MAX_LEN = psc_pkg::DEF_MAX_LEN
) (
    input  logic       clk,
    input  logic       rst_n,
    psc_in_if.sink     chars,
    psc_out_if.source  result
);
    import psc_pkg::*;

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int EXT_W = IDX_W + 2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] len_t;
    typedef logic [EXT_W-1:0] ext_t;

    // Char store: written while loading, read at i and i+gap while counting.
    char_t mem [MAX_LEN];
    char_t rd_a_reg;
    char_t rd_b_reg;

    // Two rows of palindrome flags, selected by gap parity.
    logic [MAX_LEN-1:0] flags_reg [2];

    state_t state_reg;
    state_t state_next;
    len_t   len_reg;
    logic   ovf_reg;
    idx_t   gap_reg;
    idx_t   i_reg;

    psc_op_t op;
    logic    hit;
    count_t  total;
    logic    in_fire;
    logic    out_fire;

    ext_t span_end;
    idx_t addr_b;
    idx_t inner_idx;
    logic row_done;
    logic last_gap;

    assign in_fire  = chars.valid && chars.ready;
    assign out_fire = result.valid && result.ready;

    assign span_end  = ext_t'(i_reg) + ext_t'(gap_reg);
    assign addr_b    = span_end[IDX_W-1:0];
    assign inner_idx = i_reg + idx_t'(1);
    assign row_done  = (span_end + ext_t'(1)) >= ext_t'(len_reg);
    assign last_gap  = (ext_t'(gap_reg) + ext_t'(1)) >= ext_t'(len_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && chars.last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (row_done && last_gap)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_fire)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        chars.ready  = 1'b0;
        result.valid = 1'b0;
        op.clear     = 1'b0;
        op.step      = 1'b0;
        if (gap_reg == idx_t'(0))
        begin
            op.kind = KIND_SINGLE;
        end
        else if (gap_reg == idx_t'(1))
        begin
            op.kind = KIND_PAIR;
        end
        else
        begin
            op.kind = KIND_SPAN;
        end
        unique case (state_reg)
            ST_LOAD:
            begin
                chars.ready = 1'b1;
                // ready is high here, so valid alone marks the final word
                op.clear    = chars.valid && chars.last;
            end
            ST_READ:
            begin
            end
            ST_CMP:
            begin
                op.step = 1'b1;
            end
            ST_DONE:
            begin
                result.valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            gap_reg   <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (len_reg < len_t'(MAX_LEN))
                        begin
                            len_reg <= len_reg + len_t'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    gap_reg <= '0;
                    i_reg   <= '0;
                end
                ST_CMP:
                begin
                    if (row_done)
                    begin
                        i_reg   <= '0;
                        gap_reg <= gap_reg + idx_t'(1);
                    end
                    else
                    begin
                        i_reg <= i_reg + idx_t'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_fire)
                    begin
                        len_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Char store port writes and registered reads
    always_ff @(posedge clk)
    begin
        if (in_fire && (len_reg < len_t'(MAX_LEN)))
        begin
            mem[len_reg[IDX_W-1:0]] <= chars.character;
        end
        if (state_reg == ST_READ)
        begin
            rd_a_reg <= mem[i_reg];
            rd_b_reg <= mem[addr_b];
        end
    end

    // Flag rows: entry i+1 of the current-parity row still holds gap-2.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg[0] <= '0;
            flags_reg[1] <= '0;
        end
        else if (op.step)
        begin
            flags_reg[gap_reg[0]][i_reg] <= hit;
        end
    end

    psc_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .char_a (rd_a_reg),
        .char_b (rd_b_reg),
        .inner  (flags_reg[gap_reg[0]][inner_idx]),
        .hit    (hit),
        .total  (total)
    );

    assign result.palindrome_count = total;
    assign result.overflow         = ovf_reg;

    // Loading and result delivery never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(chars.ready && result.valid))
        else $error("input ready while result pending");

    // Stored length never runs past the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= len_t'(MAX_LEN))
        else $error("length count past store depth");

    // Every read is followed by its compare.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_CMP))
        else $error("read not followed by compare");

    // Every single character counts, so the total covers the length.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((count_t'(len_reg) <= total) || total == COUNT_MAX))
        else $error("count below stored length");

    // The span end stays inside the stored string while counting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (span_end < ext_t'(len_reg)))
        else $error("span end beyond stored string");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the palindromic substring counter top level.
`timescale 1ns / 100ps

module tb;
    import psc_pkg::*;

    localparam int MAX_LEN      = DEF_MAX_LEN;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_WORDS = 990;
    localparam int HOLD_CYCLES  = 5000;   // long result-side hold-off, outlasts a full count
    localparam int DRAIN_CYCLES = 200;
    // Worst case between handshakes: the long hold-off, which covers a full
    // 64-char count, with random stalls on top. Taken ~4x over.
    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum int {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } idle_phase_t;

    typedef struct packed {
        count_t count;
        logic   overflow;
    } tally_t;

    // One row of the directed table. pin marks a row whose result is typed in.
    typedef struct {
        char_t  c;
        logic   fin;
        logic   pin;
        count_t cnt;
        logic   ovf;
    } word_row_t;

    logic clk;
    logic rst_n;

    psc_in_if  chars_if ();
    psc_out_if result_if ();

    palindromic_substring_counter_top #(
        .MAX_LEN (MAX_LEN)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (result_if)
    );

    // Typed-in expectation travels with the word that ends the string.
    logic   pin_on;
    count_t pin_count;
    logic   pin_ovf;

    // Idling knobs, in percent per cycle.
    int idle_pct;
    int stall_pct;
    bit pressure_armed;
    bit pressure_done;

    // Predictor state: the current string as the block stores it.
    char_t  str_bytes [MAX_LEN];
    int     str_len;
    bit     str_truncated;
    tally_t pending_tallies [$];

    int mismatches;
    int words_sent;
    int strings_sent;
    int results_checked;
    int truncated_strings;
    int idle_cycles;

    word_row_t directed_rows [24] = '{
        // lone bytes at both ends of the range
        '{8'h00, 1'b1, 1'b1, 12'd1, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 12'd1, 1'b0},
        // unequal pair, then equal pair
        '{8'h00, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 12'd2, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 12'd3, 1'b0},
        // odd palindrome: three singles plus the whole
        '{8'h55, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'hAA, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h55, 1'b1, 1'b1, 12'd4, 1'b0},
        // even palindrome
        '{8'h12, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h34, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h34, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h12, 1'b1, 1'b0, 12'd0, 1'b0},
        // ends match but the inner span is no palindrome
        '{8'h01, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h02, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h04, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h01, 1'b1, 1'b0, 12'd0, 1'b0},
        // run of one value: every span counts, n(n+1)/2
        '{8'h80, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 12'd10, 1'b0},
        // every char bit flips between neighbors
        '{8'h7F, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 12'd0, 1'b0},
        '{8'h7F, 1'b1, 1'b0, 12'd0, 1'b0}
    };

    // Clock and the single reset at the start of the run.
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Counts palindromic spans of the stored string diagonal by diagonal.
    // Each diagonal overwrites the row of two diagonals back, which still
    // holds the inner-span flag at i+1 when cell i is judged.
    function automatic count_t tally_palindromes(input int n);
        logic [MAX_LEN-1:0] diag [2];
        int unsigned        total;
        logic               hit;
        diag[0] = '0;
        diag[1] = '0;
        total   = 0;
        for (int g = 0; g < n; g++)
        begin
            for (int i = 0; i + g < n; i++)
            begin
                if (g == 0)
                    hit = 1'b1;
                else if (g == 1)
                    hit = (str_bytes[i] == str_bytes[i+1]);
                else
                    hit = (str_bytes[i] == str_bytes[i+g]) && diag[g & 1][i+1];
                diag[g & 1][i] = hit;
                if (hit && total < COUNT_MAX)
                    total++;
            end
        end
        return count_t'(total);
    endfunction

    // Input side: mirror the store and predict a tally at each end of string.
    always @(posedge clk)
    begin : track_chars
        tally_t want;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            words_sent++;
            if (str_len < MAX_LEN)
            begin
                str_bytes[str_len] = chars_if.character;
                str_len++;
            end
            else
                str_truncated = 1'b1;
            if (chars_if.last)
            begin
                want.count    = tally_palindromes(str_len);
                want.overflow = str_truncated;
                if (pin_on)
                begin
                    want.count    = pin_count;
                    want.overflow = pin_ovf;
                end
                if (str_truncated)
                    truncated_strings++;
                pending_tallies.push_back(want);
                str_len       = 0;
                str_truncated = 1'b0;
            end
        end
    end

    // Result side: each taken word against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        tally_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_tallies.size() == 0)
            begin
                $display("%0t: result with none expected: count=%0d overflow=%0b",
                         $time, result_if.palindrome_count, result_if.overflow);
                mismatches++;
            end
            else
            begin
                want = pending_tallies.pop_front();
                results_checked++;
                if (result_if.palindrome_count !== want.count)
                begin
                    $display("%0t: palindrome_count expected %0d got %0d",
                             $time, want.count, result_if.palindrome_count);
                    mismatches++;
                end
                if (result_if.overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %0b got %0b",
                             $time, want.overflow, result_if.overflow);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles without any handshake on either channel.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_tallies.size());
                $display("FAIL palindromic_substring_counter_top");
                $finish;
            end
        end
    end

    // Result ready: random stalls, plus one long hold-off when armed so the
    // block parks a result and then backs up the char channel.
    initial
    begin : drive_ready
        int hold_left;
        hold_left       = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_armed && !pressure_done)
            begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one word at a falling edge and returns once it is taken.
    // valid is left high; the next call or the end of stimulus decides it.
    task automatic send_word(input char_t c, input logic fin, input logic pin,
                             input count_t cnt, input logic ovf);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(negedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.character <= c;
        chars_if.last      <= fin;
        pin_on             <= pin;
        pin_count          <= cnt;
        pin_ovf            <= ovf;
        do
            @(posedge clk);
        while (!chars_if.ready);
    endtask

    // One random string. Mostly short; a few up to the store size and a few
    // past it. Content is wide random, a small alphabet, or a mirrored
    // palindrome that is sometimes broken by one stray char.
    task automatic send_random_string(inout int stored);
        char_t text [80];
        char_t alph [4];
        int    len;
        int    k;
        int    pick;
        int    half;
        pick = $urandom_range(99);
        if (pick < 4)
            len = $urandom_range(MAX_LEN + 8, MAX_LEN + 1);
        else if (pick < 12)
            len = $urandom_range(MAX_LEN, 33);
        else
            len = $urandom_range(16, 1);
        for (int a = 0; a < 4; a++)
            alph[a] = char_t'($urandom_range(255));
        k    = $urandom_range(3);
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            for (int i = 0; i < len; i++)
                text[i] = char_t'($urandom_range(255));
        end
        else if (pick < 60)
        begin
            for (int i = 0; i < len; i++)
                text[i] = alph[$urandom_range(k)];
        end
        else
        begin
            half = (len + 1) / 2;
            for (int i = 0; i < half; i++)
                text[i] = alph[$urandom_range(k)];
            for (int i = half; i < len; i++)
                text[i] = text[len - 1 - i];
            if ($urandom_range(99) < 30)
                text[$urandom_range(len - 1)] = char_t'($urandom_range(255));
        end
        for (int i = 0; i < len; i++)
            send_word(text[i], (i == len - 1), 1'b0, '0, 1'b0);
        stored += (len < MAX_LEN) ? len : MAX_LEN;   // dropped chars don't count
        strings_sent++;
    endtask

    initial
    begin : stimulus
        int stored;
        int share;
        chars_if.valid     = 1'b0;
        chars_if.character = '0;
        chars_if.last      = 1'b0;
        pin_on             = 1'b0;
        pin_count          = '0;
        pin_ovf            = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        pressure_armed     = 1'b0;
        pressure_done      = 1'b0;
        str_len            = 0;
        str_truncated      = 1'b0;
        mismatches         = 0;
        words_sent         = 0;
        strings_sent       = 0;
        results_checked    = 0;
        truncated_strings  = 0;
        stored             = 0;
        wait (rst_n === 1'b1);

        // Directed table.
        foreach (directed_rows[r])
        begin
            send_word(directed_rows[r].c, directed_rows[r].fin, directed_rows[r].pin,
                      directed_rows[r].cnt, directed_rows[r].ovf);
            if (directed_rows[r].fin)
                strings_sent++;
        end

        // Full store of one value: top of the count range, no truncation.
        for (int i = 0; i < MAX_LEN; i++)
            send_word(8'h00, (i == MAX_LEN - 1), (i == MAX_LEN - 1), 12'd2080, 1'b0);
        // Too long, final char among the dropped ones: same count, overflow set.
        for (int i = 0; i < MAX_LEN + 6; i++)
            send_word(8'hFF, (i == MAX_LEN + 5), (i == MAX_LEN + 5), 12'd2080, 1'b1);
        strings_sent += 2;

        // Random strings over four idling phases; the free-running one
        // opens with the long result hold-off.
        share = RANDOM_WORDS / 4;
        for (int p = PH_FREE; p <= PH_BOTH; p++)
        begin
            case (idle_phase_t'(p))
                PH_FREE:      begin idle_pct = 0;  stall_pct = 0;  pressure_armed = 1'b1; end
                PH_SRC_IDLE:  begin idle_pct = 64; stall_pct = 0;  end
                PH_SNK_STALL: begin idle_pct = 0;  stall_pct = 64; end
                default:      begin idle_pct = 33; stall_pct = 33; end
            endcase
            stored = 0;
            while (stored < share)
                send_random_string(stored);
        end

        @(negedge clk);
        chars_if.valid <= 1'b0;

        while (pending_tallies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d strings (%0d words, %0d truncated), %0d results checked.",
                 strings_sent, words_sent, truncated_strings, results_checked);
        $display("Idling: none, sender 64%%, receiver 64%%, both 33%%, one %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("PASS palindromic_substring_counter_top");
        else
            $display("FAIL palindromic_substring_counter_top");
        $finish;
    end

endmodule

// ===== sim.f =====
design/psc_pkg.sv
design/psc_in_if.sv
design/psc_out_if.sv
design/psc_unit.sv
design/palindromic_substring_counter_top.sv
bench/tb.sv
